FILE: hdl/pse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types, constants, the CRC-32 byte update and the size clamp for the
// stored-deflate PNG encoder.
// ----------------------------------------------------------------------------
package pse_pkg;

  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned BLOCK_MAX  = 65535;
  localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;
  localparam logic [16:0] ADLER_MOD  = 17'd65521;

  // byte positions inside the header, block header and trailer runs
  localparam logic [5:0] HDR_IHDR_LEN_LAST = 6'd11;
  localparam logic [5:0] HDR_IHDR_FIRST    = 6'd12;
  localparam logic [5:0] HDR_IHDR_LAST     = 6'd28;
  localparam logic [5:0] HDR_IDAT_LEN_LAST = 6'd36;
  localparam logic [5:0] HDR_IDAT_FIRST    = 6'd37;
  localparam logic [5:0] HDR_LAST          = 6'd42;
  localparam logic [5:0] BLK_LAST          = 6'd4;
  localparam logic [5:0] TRL_ADLER_LAST    = 6'd3;
  localparam logic [5:0] TRL_IEND_LEN_LAST = 6'd11;
  localparam logic [5:0] TRL_IEND_FIRST    = 6'd12;
  localparam logic [5:0] TRL_IEND_LAST     = 6'd15;
  localparam logic [5:0] TRL_LAST          = 6'd19;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_index_e;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_HDR  = 5'b00010,
    PH_BLK  = 5'b00100,
    PH_RAW  = 5'b01000,
    PH_TRL  = 5'b10000
  } phase_e;

  typedef struct packed {
    logic       valid;
    logic       avail_next;
    logic [7:0] data;
  } head_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       end_of_file;
  } beat_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] v);
    logic [31:0] r;
    r = c ^ {24'd0, v};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? (CRC_POLY ^ (r >> 1)) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic [12:0] clamp_size(input logic [12:0] v, input logic [12:0] vmax);
    if (v == 13'd0) begin
      return 13'd1;
    end else if (v > vmax) begin
      return vmax;
    end
    return v;
  endfunction

endpackage

FILE: hdl/pse_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_front
// Two-entry input queue: accepts image bytes and presents the oldest one
// to the emitter, with a look-ahead of the next-cycle occupancy.
// ----------------------------------------------------------------------------
module pse_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         data_byte_i,
  input  logic               pop_head_i,
  output pse_pkg::head_t     head_o
);

  logic [7:0] mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full    = (cnt_q == 2'd2);
  assign do_push = push && !full;
  assign do_pop  = pop_head_i && (cnt_q != 2'd0);

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_byte_i;
    end
  end

  assign head_o.valid      = (cnt_q != 2'd0);
  assign head_o.avail_next = (cnt_d != 2'd0);
  assign head_o.data       = mem_q[rd_q];

endmodule

FILE: hdl/pse_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_back
// File sequencer: emits header, stored block headers, filter, image bytes
// and trailer, one byte a cycle while popped, with running CRC/Adler sums.
// ----------------------------------------------------------------------------
module pse_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [12:0]        cfg_width_i,
  input  logic [12:0]        cfg_height_i,
  input  pse_pkg::head_t     head_i,
  output logic               pop_head_o,
  output logic               empty,
  input  logic               pop,
  output pse_pkg::beat_t     beat_o
);

  pse_pkg::phase_e phase_q, phase_d;
  logic [5:0]  idx_q, idx_d;
  logic        filt_q, filt_d;
  logic        started_q, started_d;
  logic [13:0] col_q, col_d;
  logic [25:0] raw_left_q, raw_left_d;
  logic [15:0] blk_left_q, blk_left_d;
  logic [15:0] adl_q, adl_d, adh_q, adh_d;
  logic [31:0] crc_q, crc_d, hcrc_q, hcrc_d;
  logic [12:0] fw_q, fw_d, fh_q, fh_d;
  logic [25:0] raw_tot_q;
  logic [31:0] idat_len_q;
  logic        out_valid_q, out_valid_d;
  pse_pkg::beat_t out_q, out_d;

  logic        adv, out_pop, emit;
  logic [7:0]  b;
  logic        do_disp, disp_avail, disp_started, disp_col0, disp_bl0;

  // frame size arithmetic, settled long before the IDAT length is sent
  logic [13:0] row_len;
  logic [14:0] row_bytes;
  logic [26:0] prod;
  logic [9:0]  q0;
  logic [16:0] rem, rem2;
  logic        ge;
  logic [10:0] blocks;
  logic [31:0] idat_len_d;

  assign row_len   = 14'({fw_q, 1'b0}) + 14'(fw_q) + 14'd1;
  assign row_bytes = 15'({fw_q, 1'b0}) + 15'(fw_q);
  assign prod      = 27'(fh_q) * 27'(row_len);

  // ceil(raw / 65535): 65536 = 65535 + 1, so one correction suffices
  always_comb begin
    q0         = raw_tot_q[25:16];
    rem        = 17'(raw_tot_q[15:0]) + 17'(q0);
    ge         = (rem >= 17'(pse_pkg::BLOCK_MAX));
    rem2       = ge ? rem - 17'(pse_pkg::BLOCK_MAX) : rem;
    blocks     = 11'(q0) + 11'(ge) + 11'(rem2 != 17'd0);
    idat_len_d = 32'd6 + 32'({blocks, 2'b00}) + 32'(blocks) + 32'(raw_tot_q);
  end

  // stored block length and raw byte to send
  logic [15:0] blk_n;
  logic [7:0]  raw_v;
  logic [16:0] lo_s, hi_s;
  logic [15:0] lo_n, hi_n;
  logic [13:0] col_inc;
  logic [31:0] hx, cx;

  assign blk_n   = (raw_left_q < 26'(pse_pkg::BLOCK_MAX)) ? raw_left_q[15:0] : 16'hFFFF;
  assign raw_v   = filt_q ? 8'h00 : head_i.data;
  assign lo_s    = 17'(adl_q) + 17'(raw_v);
  assign lo_n    = (lo_s >= pse_pkg::ADLER_MOD) ? 16'(lo_s - pse_pkg::ADLER_MOD) : lo_s[15:0];
  assign hi_s    = 17'(adh_q) + 17'(lo_n);
  assign hi_n    = (hi_s >= pse_pkg::ADLER_MOD) ? 16'(hi_s - pse_pkg::ADLER_MOD) : hi_s[15:0];
  assign col_inc = col_q + 14'd1;
  assign hx      = ~hcrc_q;
  assign cx      = ~crc_q;

  assign out_pop = pop && out_valid_q;
  assign adv     = (phase_q != pse_pkg::PH_IDLE) && (!out_valid_q || out_pop);

  // byte tables of the fixed runs
  logic [7:0] hdr_b, blk_b, trl_b;

  always_comb begin
    case (idx_q)
      6'd0:  hdr_b = 8'h89;
      6'd1:  hdr_b = 8'h50;
      6'd2:  hdr_b = 8'h4E;
      6'd3:  hdr_b = 8'h47;
      6'd4:  hdr_b = 8'h0D;
      6'd5:  hdr_b = 8'h0A;
      6'd6:  hdr_b = 8'h1A;
      6'd7:  hdr_b = 8'h0A;
      6'd11: hdr_b = 8'h0D;
      6'd12: hdr_b = 8'h49;
      6'd13: hdr_b = 8'h48;
      6'd14: hdr_b = 8'h44;
      6'd15: hdr_b = 8'h52;
      6'd18: hdr_b = {3'd0, fw_q[12:8]};
      6'd19: hdr_b = fw_q[7:0];
      6'd22: hdr_b = {3'd0, fh_q[12:8]};
      6'd23: hdr_b = fh_q[7:0];
      6'd24: hdr_b = 8'h08;
      6'd25: hdr_b = 8'h02;
      6'd29: hdr_b = hx[31:24];
      6'd30: hdr_b = hx[23:16];
      6'd31: hdr_b = hx[15:8];
      6'd32: hdr_b = hx[7:0];
      6'd33: hdr_b = idat_len_q[31:24];
      6'd34: hdr_b = idat_len_q[23:16];
      6'd35: hdr_b = idat_len_q[15:8];
      6'd36: hdr_b = idat_len_q[7:0];
      6'd37: hdr_b = 8'h49;
      6'd38: hdr_b = 8'h44;
      6'd39: hdr_b = 8'h41;
      6'd40: hdr_b = 8'h54;
      6'd41: hdr_b = 8'h78;
      6'd42: hdr_b = 8'h01;
      default: hdr_b = 8'h00;
    endcase
  end

  always_comb begin
    case (idx_q)
      6'd0:    blk_b = {7'd0, (raw_left_q <= 26'(pse_pkg::BLOCK_MAX))};
      6'd1:    blk_b = blk_n[7:0];
      6'd2:    blk_b = blk_n[15:8];
      6'd3:    blk_b = ~blk_n[7:0];
      6'd4:    blk_b = ~blk_n[15:8];
      default: blk_b = 8'h00;
    endcase
  end

  always_comb begin
    case (idx_q)
      6'd0:  trl_b = adh_q[15:8];
      6'd1:  trl_b = adh_q[7:0];
      6'd2:  trl_b = adl_q[15:8];
      6'd3:  trl_b = adl_q[7:0];
      6'd4:  trl_b = cx[31:24];
      6'd5:  trl_b = cx[23:16];
      6'd6:  trl_b = cx[15:8];
      6'd7:  trl_b = cx[7:0];
      6'd12: trl_b = 8'h49;
      6'd13: trl_b = 8'h45;
      6'd14: trl_b = 8'h4E;
      6'd15: trl_b = 8'h44;
      6'd16: trl_b = hx[31:24];
      6'd17: trl_b = hx[23:16];
      6'd18: trl_b = hx[15:8];
      6'd19: trl_b = hx[7:0];
      default: trl_b = 8'h00;
    endcase
  end

  always_comb begin
    phase_d      = phase_q;
    idx_d        = idx_q;
    filt_d       = filt_q;
    started_d    = started_q;
    col_d        = col_q;
    raw_left_d   = raw_left_q;
    blk_left_d   = blk_left_q;
    adl_d        = adl_q;
    adh_d        = adh_q;
    crc_d        = crc_q;
    hcrc_d       = hcrc_q;
    fw_d         = fw_q;
    fh_d         = fh_q;
    emit         = 1'b0;
    b            = 8'h00;
    out_d        = out_q;
    out_d.last_of_run = 1'b0;
    out_d.end_of_file = 1'b0;
    pop_head_o   = 1'b0;
    do_disp      = 1'b0;
    disp_avail   = head_i.avail_next;
    disp_started = started_q;
    disp_col0    = (col_q == 14'd0);
    disp_bl0     = (blk_left_q == 16'd0);

    case (phase_q)
      pse_pkg::PH_IDLE: begin
        if (head_i.valid) begin
          do_disp    = 1'b1;
          disp_avail = 1'b1;
        end
      end
      pse_pkg::PH_HDR: begin
        if (adv) begin
          emit = 1'b1;
          b    = hdr_b;
          if (idx_q == pse_pkg::HDR_IHDR_LEN_LAST) begin
            hcrc_d = pse_pkg::CRC_INIT;
          end else if (idx_q >= pse_pkg::HDR_IHDR_FIRST && idx_q <= pse_pkg::HDR_IHDR_LAST) begin
            hcrc_d = pse_pkg::crc_byte(hcrc_q, b);
          end
          if (idx_q == pse_pkg::HDR_IDAT_LEN_LAST) begin
            crc_d = pse_pkg::CRC_INIT;
          end else if (idx_q >= pse_pkg::HDR_IDAT_FIRST) begin
            crc_d = pse_pkg::crc_byte(crc_q, b);
          end
          if (idx_q == pse_pkg::HDR_LAST) begin
            started_d  = 1'b1;
            raw_left_d = raw_tot_q;
            blk_left_d = 16'd0;
            col_d      = 14'd0;
            adl_d      = 16'd1;
            adh_d      = 16'd0;
            filt_d     = 1'b1;
            phase_d    = pse_pkg::PH_BLK;
            idx_d      = 6'd0;
          end else begin
            idx_d = idx_q + 6'd1;
          end
        end
      end
      pse_pkg::PH_BLK: begin
        if (adv) begin
          emit  = 1'b1;
          b     = blk_b;
          crc_d = pse_pkg::crc_byte(crc_q, b);
          if (idx_q == pse_pkg::BLK_LAST) begin
            blk_left_d = blk_n;
            phase_d    = pse_pkg::PH_RAW;
            idx_d      = 6'd0;
          end else begin
            idx_d = idx_q + 6'd1;
          end
        end
      end
      pse_pkg::PH_RAW: begin
        if (adv) begin
          emit       = 1'b1;
          b          = raw_v;
          crc_d      = pse_pkg::crc_byte(crc_q, b);
          adl_d      = lo_n;
          adh_d      = hi_n;
          blk_left_d = blk_left_q - 16'd1;
          raw_left_d = raw_left_q - 26'd1;
          if (filt_q) begin
            filt_d  = 1'b0;
            phase_d = (blk_left_d == 16'd0) ? pse_pkg::PH_BLK : pse_pkg::PH_RAW;
          end else begin
            pop_head_o = 1'b1;
            col_d      = (15'(col_inc) >= row_bytes) ? 14'd0 : col_inc;
            if (raw_left_d == 26'd0) begin
              phase_d = pse_pkg::PH_TRL;
              idx_d   = 6'd0;
            end else begin
              out_d.last_of_run = 1'b1;
              do_disp   = 1'b1;
              disp_col0 = (col_d == 14'd0);
              disp_bl0  = (blk_left_d == 16'd0);
            end
          end
        end
      end
      pse_pkg::PH_TRL: begin
        if (adv) begin
          emit = 1'b1;
          b    = trl_b;
          if (idx_q <= pse_pkg::TRL_ADLER_LAST) begin
            crc_d = pse_pkg::crc_byte(crc_q, b);
          end
          if (idx_q == pse_pkg::TRL_IEND_LEN_LAST) begin
            hcrc_d = pse_pkg::CRC_INIT;
          end else if (idx_q >= pse_pkg::TRL_IEND_FIRST && idx_q <= pse_pkg::TRL_IEND_LAST) begin
            hcrc_d = pse_pkg::crc_byte(hcrc_q, b);
          end
          if (idx_q == pse_pkg::TRL_LAST) begin
            out_d.last_of_run = 1'b1;
            out_d.end_of_file = 1'b1;
            started_d    = 1'b0;
            do_disp      = 1'b1;
            disp_started = 1'b0;
          end else begin
            idx_d = idx_q + 6'd1;
          end
        end
      end
      default: begin
        phase_d = pse_pkg::PH_IDLE;
      end
    endcase

    // pick the first run of the next item
    if (do_disp) begin
      idx_d = 6'd0;
      if (!disp_avail) begin
        phase_d = pse_pkg::PH_IDLE;
      end else if (!disp_started) begin
        phase_d = pse_pkg::PH_HDR;
        fw_d    = pse_pkg::clamp_size(cfg_width_i, 13'(pse_pkg::MAX_WIDTH));
        fh_d    = pse_pkg::clamp_size(cfg_height_i, 13'(pse_pkg::MAX_HEIGHT));
      end else begin
        filt_d  = disp_col0;
        phase_d = disp_bl0 ? pse_pkg::PH_BLK : pse_pkg::PH_RAW;
      end
    end

    out_d.out_byte = emit ? b : out_q.out_byte;
    if (!emit) begin
      out_d.last_of_run = out_q.last_of_run;
      out_d.end_of_file = out_q.end_of_file;
    end
    out_valid_d = emit ? 1'b1 : (out_pop ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= pse_pkg::PH_IDLE;
      idx_q       <= 6'd0;
      filt_q      <= 1'b0;
      started_q   <= 1'b0;
      col_q       <= 14'd0;
      raw_left_q  <= 26'd0;
      blk_left_q  <= 16'd0;
      adl_q       <= 16'd1;
      adh_q       <= 16'd0;
      crc_q       <= pse_pkg::CRC_INIT;
      hcrc_q      <= pse_pkg::CRC_INIT;
      fw_q        <= 13'd1;
      fh_q        <= 13'd1;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      filt_q      <= filt_d;
      started_q   <= started_d;
      col_q       <= col_d;
      raw_left_q  <= raw_left_d;
      blk_left_q  <= blk_left_d;
      adl_q       <= adl_d;
      adh_q       <= adh_d;
      crc_q       <= crc_d;
      hcrc_q      <= hcrc_d;
      fw_q        <= fw_d;
      fh_q        <= fh_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_tot_q  <= prod[25:0];
    idat_len_q <= idat_len_d;
    out_q      <= out_d;
  end

  assign empty  = !out_valid_q;
  assign beat_o = out_q;

  a_eof_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.end_of_file) |-> out_q.last_of_run)
    else $error("end of file without end of run");

  a_pop_on_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_head_o |-> (phase_q == pse_pkg::PH_RAW && !filt_q && head_i.valid))
    else $error("input byte consumed outside a data beat");

  a_raw_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == pse_pkg::PH_RAW) |-> (blk_left_q != 16'd0 && raw_left_q != 26'd0))
    else $error("raw byte with no block or frame space left");

endmodule

FILE: hdl/png_stored_deflate_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_stored_deflate_encoder_core
// Streams an RGB8 frame in and a complete PNG file (stored deflate) out.
// ----------------------------------------------------------------------------
// Usage:
//   Configure image_width (byte address 0) and image_height (byte address 4)
//   over the APB port while the block is idle; sizes are clamped to 1..4096
//   and latched at the first byte of each frame.
//   Push image bytes (R, G, B, raster order) while full is low. Pop file
//   bytes while empty is low; last_of_run_o marks the final byte caused by
//   one input byte, end_of_file_o the last byte of the file.
// Timing:
//   One file byte leaves per cycle while pop is high. An image byte in a
//   stored block yields one file byte; a row's first byte adds a filter
//   byte, a block boundary adds five, the first byte of a frame adds 43
//   header bytes and the last adds 20 trailer bytes. The emitter sends one
//   byte per cycle while not stalled. When idle, a push reaches the output
//   through the input queue, the emitter phase and the output register.
// Reset and stall:
//   Reset empties both queues and starts a new file at the next byte. When
//   pop stays low the output register holds, the emitter stops and the
//   two-entry input queue fills, then full rises.
// ----------------------------------------------------------------------------
module png_stored_deflate_encoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input queue
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  // result queue
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        last_of_run_o,
  output logic        end_of_file_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [12:0]    width_q, height_q;
  pse_pkg::head_t head;
  pse_pkg::beat_t beat;
  logic           pop_head;
  logic           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // register file: only address bit 2 selects the register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd1;
      height_q <= 13'd1;
    end else if (cfg_wr) begin
      if (paddr[2] == pse_pkg::REG_HEIGHT) begin
        height_q <= pwdata[12:0];
      end else begin
        width_q <= pwdata[12:0];
      end
    end
  end

  assign prdata = (paddr[2] == pse_pkg::REG_HEIGHT) ? 32'(height_q) : 32'(width_q);

  // front: buffer up to two incoming bytes while other beats are sent
  pse_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .data_byte_i (data_byte_i),
    .pop_head_i  (pop_head),
    .head_o      (head)
  );

  // back: sequence the file and drive the output register
  pse_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_width_i  (width_q),
    .cfg_height_i (height_q),
    .head_i       (head),
    .pop_head_o   (pop_head),
    .empty        (empty),
    .pop          (pop),
    .beat_o       (beat)
  );

  assign out_byte_o    = beat.out_byte;
  assign last_of_run_o = beat.last_of_run;
  assign end_of_file_o = beat.end_of_file;

endmodule

FILE: verif/png_stored_deflate_encoder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_stored_deflate_encoder_checker
// Watches the image byte and file byte channels and the register port,
// predicts the PNG file byte by byte and compares every popped beat.
// ----------------------------------------------------------------------------
module png_stored_deflate_encoder_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        empty,
  input  logic        pop,
  input  logic [7:0]  out_byte_o,
  input  logic        last_of_run_o,
  input  logic        end_of_file_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          pending_o
);

  pse_pkg::beat_t file_bytes_q[$];

  logic [12:0] cfg_width, cfg_height;
  logic        in_frame;
  logic [13:0] col_bytes;
  logic [25:0] raw_remaining;
  logic [16:0] block_remaining;
  logic [15:0] adler_a, adler_b;
  logic [31:0] idat_crc;
  logic [12:0] frame_width;

  function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] v);
    logic [31:0] r;
    r = c ^ {24'd0, v};
    for (int k = 0; k < 8; k++) r = r[0] ? (32'hEDB88320 ^ (r >> 1)) : (r >> 1);
    return r;
  endfunction

  // Queue one file byte; fold it into a running CRC when asked.
  task automatic emit(logic [7:0] v, ref logic [31:0] crc, input bit fold);
    pse_pkg::beat_t b;
    b.out_byte = v;
    b.last_of_run = 1'b0;
    b.end_of_file = 1'b0;
    file_bytes_q.insert(file_bytes_q.size(), b);
    if (fold) crc = crc_step(crc, v);
  endtask

  task automatic emit_word(logic [31:0] w, ref logic [31:0] crc, input bit fold);
    for (int i = 3; i >= 0; i--) emit(w[8*i +: 8], crc, fold);
  endtask

  task automatic emit_raw(logic [7:0] v);
    logic [16:0] n;
    if (block_remaining == 0) begin
      n = (raw_remaining < 65535) ? raw_remaining[16:0] : 17'd65535;
      emit((raw_remaining <= 65535) ? 8'd1 : 8'd0, idat_crc, 1);
      emit(n[7:0], idat_crc, 1);
      emit(n[15:8], idat_crc, 1);
      emit(~n[7:0], idat_crc, 1);
      emit(~n[15:8], idat_crc, 1);
      block_remaining = n;
    end
    emit(v, idat_crc, 1);
    adler_a = ({1'b0, adler_a} + v >= 65521) ? adler_a + v - 16'd65521 : adler_a + v;
    adler_b = ({1'b0, adler_b} + adler_a >= 65521) ? adler_b + adler_a - 16'd65521
                                                 : adler_b + adler_a;
    if (block_remaining > 0) block_remaining--;
    if (raw_remaining > 0) raw_remaining--;
  endtask

  task automatic open_frame();
    logic [12:0] w, h;
    logic [31:0] crc, dummy;
    longint raw, blocks;
    byte unsigned sig[8] = '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
    w = (cfg_width == 0) ? 13'd1 :
        (cfg_width > pse_pkg::MAX_WIDTH ? 13'(pse_pkg::MAX_WIDTH) : cfg_width);
    h = (cfg_height == 0) ? 13'd1 :
        (cfg_height > pse_pkg::MAX_HEIGHT ? 13'(pse_pkg::MAX_HEIGHT) : cfg_height);
    frame_width = w;
    raw = longint'(h) * (longint'(w) * 3 + 1);
    blocks = (raw + 65534) / 65535;
    raw_remaining = raw[25:0];
    foreach (sig[i]) emit(sig[i], dummy, 0);
    emit_word(32'd13, dummy, 0);
    crc = 32'hFFFFFFFF;
    emit_word(32'h49484452, crc, 1);
    emit_word({19'd0, w}, crc, 1);
    emit_word({19'd0, h}, crc, 1);
    emit(8'd8, crc, 1);
    emit(8'd2, crc, 1);
    emit(8'd0, crc, 1);
    emit(8'd0, crc, 1);
    emit(8'd0, crc, 1);
    emit_word(~crc, dummy, 0);
    emit_word(32'(2 + 5 * blocks + raw + 4), dummy, 0);
    idat_crc = 32'hFFFFFFFF;
    emit_word(32'h49444154, idat_crc, 1);
    emit(8'h78, idat_crc, 1);
    emit(8'h01, idat_crc, 1);
    in_frame = 1;
    col_bytes = 0;
    block_remaining = 0;
    adler_a = 1;
    adler_b = 0;
  endtask

  task automatic close_frame();
    logic [31:0] crc, dummy;
    emit_word({adler_b, adler_a}, idat_crc, 1);
    emit_word(~idat_crc, dummy, 0);
    emit_word(32'd0, dummy, 0);
    crc = 32'hFFFFFFFF;
    emit_word(32'h49454E44, crc, 1);
    emit_word(~crc, dummy, 0);
    file_bytes_q[$].end_of_file = 1'b1;
    in_frame = 0;
  endtask

  // Predict every byte that one image byte causes.
  task automatic predict_file_bytes(logic [7:0] v);
    if (!in_frame) open_frame();
    if (col_bytes == 0) emit_raw(8'd0);
    emit_raw(v);
    col_bytes++;
    if (col_bytes >= frame_width * 3) col_bytes = 0;
    if (raw_remaining == 0) close_frame();
    file_bytes_q[$].last_of_run = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pse_pkg::beat_t exp_b;
    if (!rst_ni) begin
      file_bytes_q.delete();
      fail_count_o <= 0;
      pending_o <= 0;
      cfg_width = 13'd1;
      cfg_height = 13'd1;
      in_frame = 0;
      col_bytes = 0;
      raw_remaining = 0;
      block_remaining = 0;
    end else begin
      // compare first: a beat popped now was predicted at an earlier edge
      if (pop && !empty) begin
        if (file_bytes_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected file byte %02h", out_byte_o);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_b = file_bytes_q.pop_front();
          if (exp_b.out_byte !== out_byte_o || exp_b.last_of_run !== last_of_run_o ||
              exp_b.end_of_file !== end_of_file_o) begin
            if (fail_count_o < 10)
              $display("mismatch: expected %02h/%0b/%0b got %02h/%0b/%0b",
                       exp_b.out_byte, exp_b.last_of_run, exp_b.end_of_file,
                       out_byte_o, last_of_run_o, end_of_file_o);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (pse_pkg::reg_index_e'(paddr[2]) == pse_pkg::REG_WIDTH) cfg_width = pwdata[12:0];
        else cfg_height = pwdata[12:0];
      end
      if (push && !full) predict_file_bytes(data_byte_i);
      pending_o <= file_bytes_q.size();
    end
  end

endmodule

FILE: verif/tb_png_stored_deflate_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_png_stored_deflate_encoder_core
// Streams small directed and random RGB frames through the DUT, with idle and
// stall phases on both sides; the checker predicts and compares every byte.
// ----------------------------------------------------------------------------
module tb_png_stored_deflate_encoder_core;

  localparam int STALL_LIMIT = 20000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        push = 0;
  logic        full;
  logic [7:0]  data_byte_i = 0;
  logic        empty;
  logic        pop = 0;
  logic [7:0]  out_byte_o;
  logic        last_of_run_o, end_of_file_o;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending;
  int          push_idle_pct, pop_stall_pct;
  int          quiet_cycles;

  always #6 clk_i = ~clk_i;

  png_stored_deflate_encoder_core u_dut (.*);

  png_stored_deflate_encoder_checker u_chk (
    .clk_i, .rst_ni, .push, .full, .data_byte_i, .empty, .pop, .out_byte_o,
    .last_of_run_o, .end_of_file_o, .psel, .penable, .pwrite, .paddr, .pwdata,
    .pready, .fail_count_o(fail_count), .pending_o(pending)
  );

  // Drop pop at random per the current stall rate; fresh each edge.
  always @(posedge clk_i) begin
    if (rst_ni) pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  // Watchdog: end the run after a long stretch with no beat moving.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || !rst_ni) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(pse_pkg::reg_index_e idx, logic [31:0] value);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
  endtask

  // Push one image byte after random idle gaps; hold it while full is high.
  task automatic push_byte(logic [7:0] v);
    while ($urandom_range(99) < push_idle_pct) begin
      push <= 0;
      @(posedge clk_i);
    end
    push <= 1;
    data_byte_i <= v;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  // Wait for every predicted byte, then a margin beyond the trailer run.
  task automatic drain();
    push <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  // Configure a size and send one full frame.
  task automatic send_frame(int w, int h, int mode);
    int wc, hc, n;
    write_reg(pse_pkg::REG_WIDTH, w);
    write_reg(pse_pkg::REG_HEIGHT, h);
    wc = (w == 0) ? 1 : (w > 4096 ? 4096 : w);
    hc = (h == 0) ? 1 : (h > 4096 ? 4096 : h);
    n = wc * hc * 3;
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: push_byte(8'h00);
        1: push_byte(8'hFF);
        2: push_byte((i & 1) ? 8'hAA : 8'h55);
        default: push_byte(8'($urandom));
      endcase
    end
    drain();
  endtask

  initial begin
    push_idle_pct = 0;
    pop_stall_pct = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: default size, zero size clamps, field extremes
    for (int i = 0; i < 256; i += 255) begin
      push_byte(8'(i));
      push_byte(8'hFF);
      push_byte(8'h00);
    end
    drain();
    send_frame(0, 0, 1);
    send_frame(2, 1, 0);
    send_frame(1, 2, 2);
    // random frames across idle and stall phases, small sizes
    for (int ph = 0; ph < 4; ph++) begin
      push_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 61 : 17) : 0;
      pop_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 61 : 17) : 0;
      for (int f = 0; f < 3; f++) send_frame($urandom_range(1, 4), $urandom_range(1, 2), 3);
    end
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/pse_pkg.sv
hdl/pse_front.sv
hdl/pse_back.sv
hdl/png_stored_deflate_encoder_core.sv
verif/png_stored_deflate_encoder_checker.sv
verif/tb_png_stored_deflate_encoder_core.sv
